FILE: rtl/pre_pkg.sv
// ----------------------------------------------------------------------------
// pre_pkg
// shared types and constants of the page replacement engine
// ----------------------------------------------------------------------------
package pre_pkg;

  localparam int PageW    = 21;
  localparam int FrameW   = 10;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam logic [31:0] LfsrTaps = 32'h8020_0003;

  localparam logic [CfgIdxW-1:0] RegPolicy    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPageShift = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFrameCnt  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSeed      = 2'd3;

  localparam logic [1:0] PolLru    = 2'd0;
  localparam logic [1:0] PolFifo   = 2'd1;
  localparam logic [1:0] PolRandom = 2'd2;

endpackage

FILE: rtl/page_replacement_engine_unit.sv
// ----------------------------------------------------------------------------
// page_replacement_engine_unit
// resident page lookup with lru, fifo or random replacement
// ----------------------------------------------------------------------------
// One access at a time: busy rises on start and the result strobe comes after
// a walk of the age-ordered frame list, one read state and one compare state
// per resident frame visited (tag and link memories with registered reads),
// plus setup and update states. A fifo or lru replacement adds a read of the
// oldest frame. A random replacement adds a bit-serial modulo of the 32-bit
// LFSR value by the used frame count and a second walk up to the chosen
// position. The result is valid for one cycle; the receiver cannot stall.
module page_replacement_engine_unit
  import pre_pkg::*;
#(
  parameter int MAX_FRAMES = 1024,
  parameter int ADDR_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                cmd,
  input  logic [ADDR_BITS-1:0] address,
  output logic                done,
  output logic                hit,
  output logic                filled,
  output logic                replaced,
  output logic [FrameW-1:0]   frame,
  output logic [PageW-1:0]    evicted_page,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int FW = $clog2(MAX_FRAMES);
  localparam int CW = $clog2(MAX_FRAMES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CMP, S_MISS, S_MOD, S_WALK, S_WCMP, S_UPD, S_UPD2, S_DONE
  } state_t;

  state_t state;

  logic [PageW-1:0] tags  [MAX_FRAMES];
  logic [FW-1:0]    links [MAX_FRAMES];
  logic [PageW-1:0] tag_q;
  logic [FW-1:0]    link_q;
  logic             tag_we, link_we;
  logic [FW-1:0]    tag_wa, link_wa, rd_a;
  logic [PageW-1:0] tag_wd;
  logic [FW-1:0]    link_wd;

  logic [1:0]    policy;
  logic [4:0]    page_shift;
  logic [10:0]   frame_count;
  logic [31:0]   lfsr;

  logic [PageW-1:0] page;
  logic [FW-1:0]    oldest, newest, cur, prev;
  logic             has_prev;
  logic [CW-1:0]    used, cnt;
  logic [CW-1:0]    cap;
  logic             r_hit, r_fill, r_repl;
  logic [PageW-1:0] r_evict;
  logic [FW-1:0]    r_frame;
  logic [31:0]      rem;
  logic [31:0]      dvd;
  logic [5:0]       mcnt;

  logic [4:0]  shift_sat;
  logic [31:0] lfsr_nx;
  logic [32:0] rem_sh;

  always_comb begin
    shift_sat = page_shift < 5'd11 ? 5'd11 : (page_shift > 5'd16 ? 5'd16 : page_shift);
    lfsr_nx = lfsr[0] ? ((lfsr >> 1) ^ LfsrTaps) : (lfsr >> 1);
    rem_sh = {rem, dvd[31]};
  end

  always_ff @(posedge clk) begin
    if (tag_we) tags[tag_wa] <= tag_wd;
    if (link_we) links[link_wa] <= link_wd;
    tag_q  <= tags[rd_a];
    link_q <= links[rd_a];
  end

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  always_comb begin
    tag_we = 1'b0; link_we = 1'b0;
    tag_wa = cur; link_wa = cur; tag_wd = page; link_wd = '0;
    rd_a = cur;
    unique case (state)
      S_MISS: begin
        if (used < cap) begin
          tag_we = 1'b1; tag_wa = used[FW-1:0];
          link_we = 1'b1; link_wa = used[FW-1:0]; link_wd = '0;
        end
      end
      S_UPD: begin
        if (r_repl) begin
          tag_we = 1'b1; tag_wa = r_frame;
        end
        if (r_fill && used != '0) begin
          link_we = 1'b1; link_wa = newest; link_wd = r_frame;
        end else if (r_frame != newest &&
                     (r_repl ? policy != PolRandom : policy == PolLru)) begin
          link_we = has_prev; link_wa = prev; link_wd = link_q;
        end
      end
      S_UPD2: begin
        link_we = 1'b1; link_wa = newest; link_wd = r_frame;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      policy <= PolLru;
      page_shift <= 5'd12;
      frame_count <= 11'd1024;
      lfsr <= 32'd1;
      oldest <= '0; newest <= '0; used <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          RegPolicy:    policy <= cfg_data[1:0];
          RegPageShift: page_shift <= cfg_data[4:0];
          RegFrameCnt:  frame_count <= cfg_data[10:0];
          RegSeed:      lfsr <= (cfg_data == '0) ? 32'd1 : cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            page <= PageW'(address >> shift_sat);
            cap <= (frame_count < 11'd2) ? CW'(2) :
                   ((32'(frame_count) > MAX_FRAMES) ? CW'(MAX_FRAMES) : CW'(frame_count));
            cur <= oldest; cnt <= '0; has_prev <= 1'b0; prev <= '0;
            r_hit <= 1'b0; r_fill <= 1'b0; r_repl <= 1'b0; r_evict <= '0;
            state <= (used == '0) ? S_MISS : S_RD;
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (r_repl) begin
            r_evict <= tag_q; state <= S_UPD;
          end else if (tag_q == page) begin
            r_hit <= 1'b1; r_frame <= cur; state <= S_UPD;
          end else if (cnt + 1'b1 == used) begin
            state <= S_MISS;
          end else begin
            prev <= cur; has_prev <= 1'b1; cur <= link_q; cnt <= cnt + 1'b1;
            state <= S_RD;
          end
        end
        S_MISS: begin
          has_prev <= 1'b0;
          if (used < cap) begin
            r_fill <= 1'b1; r_frame <= used[FW-1:0];
            state <= S_UPD;
          end else begin
            r_repl <= 1'b1; cur <= oldest; r_frame <= oldest; cnt <= '0;
            if (policy == PolRandom) begin
              lfsr <= lfsr_nx; dvd <= lfsr_nx; rem <= '0; mcnt <= '0;
              state <= S_MOD;
            end else state <= S_RD;
          end
        end
        S_MOD: begin
          if (rem_sh >= 33'(used)) rem <= 32'(rem_sh - 33'(used));
          else rem <= rem_sh[31:0];
          dvd <= dvd << 1;
          mcnt <= mcnt + 1'b1;
          if (mcnt == 6'd31) state <= S_WALK;
        end
        S_WALK: state <= S_WCMP;
        S_WCMP: begin
          if (cnt == CW'(rem)) begin
            r_frame <= cur; r_evict <= tag_q; state <= S_UPD;
          end else begin
            cur <= link_q; cnt <= cnt + 1'b1; state <= S_WALK;
          end
        end
        S_UPD: begin
          if (r_fill) begin
            if (used == '0) oldest <= r_frame;
            newest <= r_frame;
            used <= used + 1'b1;
            state <= S_DONE;
          end else if (r_frame != newest &&
                       (r_repl ? policy != PolRandom : policy == PolLru)) begin
            if (!has_prev) oldest <= link_q;
            state <= S_UPD2;
          end else state <= S_DONE;
        end
        S_UPD2: begin
          newest <= r_frame;
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          hit <= r_hit; filled <= r_fill; replaced <= r_repl;
          frame <= FrameW'(r_frame);
          evicted_page <= r_repl ? r_evict : '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");
  assert property (@(posedge clk) disable iff (rst)
                   done |-> ($countones({hit, filled, replaced}) == 1))
    else $error("result kind not exclusive");
  assert property (@(posedge clk) disable iff (rst) used <= CW'(MAX_FRAMES))
    else $error("frame count overflow");
  assert property (@(posedge clk) disable iff (rst) (done && !replaced) |-> evicted_page == '0)
    else $error("evicted page without replacement");

endmodule
